// ===== hw/rtl/vaft_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vaft_pkg: shared constants for the vector angle block
// Default sizes, the fixed-point guard width and the CORDIC arctangent table
// in units of 2^-32 turn.
// ----------------------------------------------------------------------------
package vaft_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int ITERATIONS_DEF  = 16;

    // Fraction bits added below the integer coordinates before rotating.
    localparam int GUARD_BITS = 24;

    // The angle accumulator is a 32-bit fraction of one turn.
    localparam int ACC_WIDTH = 32;
    localparam logic [ACC_WIDTH-1:0] HALF_TURN = 32'h8000_0000;

    // round(atan(2^-idx) / (2*pi) * 2^32)
    function automatic logic [ACC_WIDTH-1:0] atan_entry(input logic [4:0] idx);
        logic [ACC_WIDTH-1:0] val;
        begin
            case (idx)
                5'd0:    val = 32'd536870912;
                5'd1:    val = 32'd316933406;
                5'd2:    val = 32'd167458907;
                5'd3:    val = 32'd85004756;
                5'd4:    val = 32'd42667331;
                5'd5:    val = 32'd21354465;
                5'd6:    val = 32'd10679838;
                5'd7:    val = 32'd5340245;
                5'd8:    val = 32'd2670163;
                5'd9:    val = 32'd1335087;
                5'd10:   val = 32'd667544;
                5'd11:   val = 32'd333772;
                5'd12:   val = 32'd166886;
                5'd13:   val = 32'd83443;
                5'd14:   val = 32'd41722;
                5'd15:   val = 32'd20861;
                5'd16:   val = 32'd10430;
                5'd17:   val = 32'd5215;
                5'd18:   val = 32'd2608;
                5'd19:   val = 32'd1304;
                5'd20:   val = 32'd652;
                5'd21:   val = 32'd326;
                5'd22:   val = 32'd163;
                5'd23:   val = 32'd81;
                5'd24:   val = 32'd41;
                5'd25:   val = 32'd20;
                5'd26:   val = 32'd10;
                5'd27:   val = 32'd5;
                5'd28:   val = 32'd3;
                5'd29:   val = 32'd1;
                5'd30:   val = 32'd1;
                default: val = 32'd0;
            endcase
            return val;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vaft_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vaft_prep: difference vector and half-plane fold
// Forms center minus point, folds the left half plane onto the right one
// and scales the vector up by the guard bits.
// ----------------------------------------------------------------------------
module vaft_prep
    import vaft_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int XW          = COORD_WIDTH_DEF + GUARD_BITS + 4
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  signed [COORD_WIDTH-1:0] center_x,
    input  wire  signed [COORD_WIDTH-1:0] center_y,
    input  wire  signed [COORD_WIDTH-1:0] point_x,
    input  wire  signed [COORD_WIDTH-1:0] point_y,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic signed [XW-1:0]         out_x,
    output logic signed [XW-1:0]         out_y,
    output logic [ACC_WIDTH-1:0]         out_z
);

    logic signed [COORD_WIDTH:0] dx_raw;
    logic signed [COORD_WIDTH:0] dy_raw;
    logic signed [COORD_WIDTH:0] dx_adj;
    logic signed [COORD_WIDTH:0] dy_adj;
    logic                        flip;
    logic                        valid_reg;
    logic signed [XW-1:0]        x_reg;
    logic signed [XW-1:0]        y_reg;
    logic [ACC_WIDTH-1:0]        z_reg;
    logic signed [XW-1:0]        x_next;
    logic signed [XW-1:0]        y_next;
    logic [ACC_WIDTH-1:0]        z_next;

    always_comb
    begin
        // Equal x coordinates count as dx = -1, so a zero vector gives half a turn.
        if (center_x == point_x)
        begin
            dx_raw = '1;
        end
        else
        begin
            dx_raw = (COORD_WIDTH + 1)'(center_x) - (COORD_WIDTH + 1)'(point_x);
        end
        dy_raw = (COORD_WIDTH + 1)'(center_y) - (COORD_WIDTH + 1)'(point_y);
        flip   = dx_raw[COORD_WIDTH];
        dx_adj = flip ? -dx_raw : dx_raw;
        dy_adj = flip ? -dy_raw : dy_raw;
        x_next = XW'(dx_adj) <<< GUARD_BITS;
        y_next = XW'(dy_adj) <<< GUARD_BITS;
        z_next = flip ? HALF_TURN : '0;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/vaft_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vaft_cell: one CORDIC vectoring micro-rotation
// Rotates the vector toward the x axis by atan(2^-SHIFT) and accumulates
// the angle, holding the result in its own stage register.
// ----------------------------------------------------------------------------
module vaft_cell
    import vaft_pkg::*;
#(
    parameter int XW    = COORD_WIDTH_DEF + GUARD_BITS + 4,
    parameter int SHIFT = 0
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire  signed [XW-1:0]  in_x,
    input  wire  signed [XW-1:0]  in_y,
    input  wire  [ACC_WIDTH-1:0]  in_z,
    output logic                  out_valid,
    input  wire                   out_ready,
    output logic signed [XW-1:0]  out_x,
    output logic signed [XW-1:0]  out_y,
    output logic [ACC_WIDTH-1:0]  out_z
);

    localparam logic [ACC_WIDTH-1:0] STEP_ANGLE = atan_entry(5'(SHIFT));

    logic                  valid_reg;
    logic signed [XW-1:0]  x_reg;
    logic signed [XW-1:0]  y_reg;
    logic [ACC_WIDTH-1:0]  z_reg;
    logic signed [XW-1:0]  x_shift;
    logic signed [XW-1:0]  y_shift;
    logic signed [XW-1:0]  x_next;
    logic signed [XW-1:0]  y_next;
    logic [ACC_WIDTH-1:0]  z_next;

    always_comb
    begin
        x_shift = in_x >>> SHIFT;
        y_shift = in_y >>> SHIFT;
        // A zero y rotates the counter-clockwise way.
        if (in_y > 0)
        begin
            x_next = in_x + y_shift;
            y_next = in_y - x_shift;
            z_next = in_z + STEP_ANGLE;
        end
        else
        begin
            x_next = in_x - y_shift;
            y_next = in_y + x_shift;
            z_next = in_z - STEP_ANGLE;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/vaft_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vaft_round: output rounding and result register
// Rounds the 32-bit turn fraction to nearest, halves up, wrapping at one
// full turn, and holds the result until the consumer takes it.
// ----------------------------------------------------------------------------
module vaft_round
    import vaft_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire  [ACC_WIDTH-1:0]    in_z,
    output logic                    out_valid,
    input  wire                     out_ready,
    output logic [ANGLE_WIDTH-1:0]  angle_turns
);

    localparam int DROP = ACC_WIDTH - ANGLE_WIDTH;

    logic [ANGLE_WIDTH-1:0] rounded;
    logic                   valid_reg;
    logic [ANGLE_WIDTH-1:0] angle_reg;

    if (DROP == 0)
    begin : g_full
        assign rounded = in_z;
    end
    else
    begin : g_round
        localparam logic [ACC_WIDTH-1:0] HALF_LSB = ACC_WIDTH'(1) << (DROP - 1);
        logic [ACC_WIDTH-1:0] sum;
        assign sum     = in_z + HALF_LSB;
        assign rounded = sum[ACC_WIDTH-1:DROP];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            angle_reg <= rounded;
        end
    end

    assign out_valid   = valid_reg;
    assign angle_turns = angle_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/vector_angle_full_turn.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector_angle_full_turn: full-turn angle of (center - point)
// Pipelined CORDIC vectoring unit returning the angle of the difference
// vector as an unsigned fraction of one turn, zero along positive x.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | center_x, center_y, point_x, point_y
//  output   | out_valid / out_ready| angle_turns
//
// One transaction enters per cycle and one result leaves per cycle while the output is not stalled.
// The stages are the preparation stage, one cell per micro-rotation,
// and the rounding stage that is also the output register.
// Each stage takes new data when it is empty or its neighbor takes its contents,
// so bubbles close up while the output stalls; in_ready falls only when every
// stage holds a transaction and out_ready is low. Reset clears only valid bits.
//
// The difference vector is folded into the right half plane (adding half a
// turn) and scaled by 2^GUARD_BITS. Each cell then rotates by atan(2^-i),
// steering on the sign of y, while the 32-bit angle accumulator wraps modulo
// one full turn. Equal x coordinates are treated as dx = -1, which makes a
// zero vector read as half a turn.
// ----------------------------------------------------------------------------
module vector_angle_full_turn
    import vaft_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    parameter int ITERATIONS  = ITERATIONS_DEF
)
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire  signed [COORD_WIDTH-1:0] center_x,
    input  wire  signed [COORD_WIDTH-1:0] center_y,
    input  wire  signed [COORD_WIDTH-1:0] point_x,
    input  wire  signed [COORD_WIDTH-1:0] point_y,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic [ANGLE_WIDTH-1:0]        angle_turns
);

    // Coordinate difference (COORD_WIDTH + 1 bits) plus guard bits, with room
    // for the CORDIC gain and the diagonal magnitude.
    localparam int XW = COORD_WIDTH + GUARD_BITS + 4;

    // Link k feeds cell k; link ITERATIONS feeds the rounding stage.
    logic                 link_valid [ITERATIONS+1];
    logic                 link_ready [ITERATIONS+1];
    logic signed [XW-1:0] link_x     [ITERATIONS+1];
    logic signed [XW-1:0] link_y     [ITERATIONS+1];
    logic [ACC_WIDTH-1:0] link_z     [ITERATIONS+1];

    vaft_prep #(
        .COORD_WIDTH (COORD_WIDTH),
        .XW          (XW)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .center_x  (center_x),
        .center_y  (center_y),
        .point_x   (point_x),
        .point_y   (point_y),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_x     (link_x[0]),
        .out_y     (link_y[0]),
        .out_z     (link_z[0])
    );

    for (genvar k = 0; k < ITERATIONS; k++)
    begin : g_cell
        vaft_cell #(
            .XW    (XW),
            .SHIFT (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[k]),
            .in_ready  (link_ready[k]),
            .in_x      (link_x[k]),
            .in_y      (link_y[k]),
            .in_z      (link_z[k]),
            .out_valid (link_valid[k+1]),
            .out_ready (link_ready[k+1]),
            .out_x     (link_x[k+1]),
            .out_y     (link_y[k+1]),
            .out_z     (link_z[k+1])
        );
    end

    vaft_round #(
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (link_valid[ITERATIONS]),
        .in_ready    (link_ready[ITERATIONS]),
        .in_z        (link_z[ITERATIONS]),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .angle_turns (angle_turns)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/vaft_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vaft_checker: port-level checks for the vector angle block
// Tracks transactions in flight from the ports and checks them against the
// pipeline depth; bound to the top level.
// ----------------------------------------------------------------------------
module vaft_checker
    import vaft_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    parameter int DEPTH       = ITERATIONS_DEF + 2
)
(
    input wire                   clk,
    input wire                   rst_n,
    input wire                   in_valid,
    input wire                   in_ready,
    input wire                   out_valid,
    input wire                   out_ready,
    input wire [ANGLE_WIDTH-1:0] angle_turns
);

    localparam int CW = $clog2(DEPTH + 2);

    logic [CW-1:0] inflight_reg;
    logic [CW-1:0] inflight_next;
    logic          in_fire;
    logic          out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_fire && !out_fire)
        begin
            inflight_next = inflight_reg + CW'(1);
        end
        else if (out_fire && !in_fire)
        begin
            inflight_next = inflight_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(angle_turns))
        else $error("result changed or vanished while stalled");

    // No result appears without a transaction in flight.
    a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == '0 |-> !out_valid)
        else $error("result without a pending transaction");

    // The pipeline never holds more than its stage count.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CW'(DEPTH))
        else $error("more transactions in flight than stages");

    // Input back-pressure only when every stage is occupied.
    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> inflight_reg == CW'(DEPTH))
        else $error("input stalled while the pipeline has a free stage");

endmodule

bind vector_angle_full_turn vaft_checker #(
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .DEPTH       (ITERATIONS + 2)
) u_vaft_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .angle_turns (angle_turns)
);
`default_nettype wire

// ===== tb/angle_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_checker: scoreboard for the full-turn vector angle block
// Watches both channels, computes the angle of every accepted coordinate
// transaction with its own CORDIC model and compares it with the results.
// ----------------------------------------------------------------------------
module angle_checker
    import vaft_pkg::*;
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    input  wire                                in_ready,
    input  wire signed [COORD_WIDTH_DEF-1:0]   center_x,
    input  wire signed [COORD_WIDTH_DEF-1:0]   center_y,
    input  wire signed [COORD_WIDTH_DEF-1:0]   point_x,
    input  wire signed [COORD_WIDTH_DEF-1:0]   point_y,
    input  wire                                out_valid,
    input  wire                                out_ready,
    input  wire        [ANGLE_WIDTH_DEF-1:0]   angle_turns,
    output int                                 mismatch_count,
    output int                                 results_pending
);

    typedef logic signed [COORD_WIDTH_DEF-1:0] coord_t;
    typedef logic [ANGLE_WIDTH_DEF-1:0] angle_t;

    typedef struct {
        angle_t angle;
        coord_t cx;
        coord_t cy;
        coord_t px;
        coord_t py;
    } pending_angle_t;

    localparam int DROP_BITS = ACC_WIDTH - ANGLE_WIDTH_DEF;

    // Micro-rotation angles, round(atan(2^-i) / (2*pi) * 2^32).
    localparam logic [0:31][ACC_WIDTH-1:0] ATAN_TURNS = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    pending_angle_t angle_queue[$];

    // Angle of (center - point) as a fraction of a turn.
    function automatic angle_t full_turn_angle(input coord_t cx, input coord_t cy,
                                               input coord_t px, input coord_t py);
        longint dx;
        longint dy;
        longint xr;
        longint yr;
        longint xs;
        longint ys;
        int s;
        logic [ACC_WIDTH-1:0] z;
        logic [ACC_WIDTH:0] rounded;
        begin
            z = '0;
            // Equal x coordinates always count as a vector pointing to negative x.
            if (cx == px)
                dx = -1;
            else
                dx = longint'(cx) - longint'(px);
            dy = longint'(cy) - longint'(py);
            // Fold the left half plane over and account for it with half a turn.
            if (dx < 0)
            begin
                dx = -dx;
                dy = -dy;
                z  = HALF_TURN;
            end
            xr = dx <<< GUARD_BITS;
            yr = dy <<< GUARD_BITS;
            for (int i = 0; i < ITERATIONS_DEF; i++)
            begin
                s  = i & 31;
                xs = xr >>> s;
                ys = yr >>> s;
                if (yr > 0)
                begin
                    xr = xr + ys;
                    yr = yr - xs;
                    z  = z + ATAN_TURNS[s];
                end
                else
                begin
                    xr = xr - ys;
                    yr = yr + xs;
                    z  = z - ATAN_TURNS[s];
                end
            end
            rounded = {1'b0, z} + ((ACC_WIDTH+1)'(1) << (DROP_BITS - 1));
            return rounded[DROP_BITS +: ANGLE_WIDTH_DEF];
        end
    endfunction

    task automatic report_mismatch(input string msg);
        begin
            $display("%0t ns: angle error: %s", $time, msg);
            mismatch_count = mismatch_count + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pending_angle_t head;
        pending_angle_t entry;
        if (!rst_n)
        begin
            angle_queue.delete();
            mismatch_count  = 0;
            results_pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (angle_queue.size() == 0)
                    report_mismatch($sformatf("result %0d with no transaction waiting",
                                              angle_turns));
                else
                begin
                    head = angle_queue.pop_front();
                    if (angle_turns !== head.angle)
                        report_mismatch($sformatf(
                            "center (%0d,%0d) point (%0d,%0d): got %0d, want %0d",
                            head.cx, head.cy, head.px, head.py, angle_turns, head.angle));
                end
            end
            if (in_valid && in_ready)
            begin
                entry.cx    = center_x;
                entry.cy    = center_y;
                entry.px    = point_x;
                entry.py    = point_y;
                entry.angle = full_turn_angle(center_x, center_y, point_x, point_y);
                angle_queue.push_back(entry);
            end
            results_pending = angle_queue.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level of the vector angle testbench
// Drives coordinate transactions into the block under several idle and stall
// mixes, lets the checker score every result and prints the verdict.
// ----------------------------------------------------------------------------
module tb;
    import vaft_pkg::*;

    typedef logic signed [COORD_WIDTH_DEF-1:0] coord_t;

    // Pipeline depth: preparation stage, one cell per micro-rotation, rounding.
    localparam int PIPE_DEPTH = ITERATIONS_DEF + 2;

    // The output is held off this long once, which is far more than the
    // pipeline can buffer, so the input side must back up.
    localparam int LONG_HOLD_CYCLES = 4 * PIPE_DEPTH;

    localparam int RANDOM_PER_PHASE = 240;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    coord_t center_x;
    coord_t center_y;
    coord_t point_x;
    coord_t point_y;
    logic   out_valid;
    logic   out_ready;
    logic [ANGLE_WIDTH_DEF-1:0] angle_turns;

    int mismatch_count;
    int results_pending;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int  idle_pct  = 0;
    int  stall_pct = 0;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    bit  long_hold_req = 1'b0;

    vector_angle_full_turn dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .center_x    (center_x),
        .center_y    (center_y),
        .point_x     (point_x),
        .point_y     (point_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .angle_turns (angle_turns)
    );

    angle_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .center_x        (center_x),
        .center_y        (center_y),
        .point_x         (point_x),
        .point_y         (point_y),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .angle_turns     (angle_turns),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: even the slowest correct run finishes well inside this time.
    initial
    begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver. It decides out_ready on every falling edge. A long hold-off
    // is counted here, in cycles, so the sender keeps offering transactions
    // meanwhile and the pipeline fills up completely.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Offers one transaction, after random idle cycles, and returns at the
    // rising edge where it is accepted. The payload stays put until the
    // transaction is accepted, and valid is never dropped and raised in the same step.
    task automatic send_point_pair(input coord_t cx, input coord_t cy,
                                   input coord_t px, input coord_t py);
        begin
            @(negedge clk);
            while ($urandom_range(0, 99) < idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            center_x <= cx;
            center_y <= cy;
            point_x  <= px;
            point_y  <= py;
            do
                @(posedge clk);
            while (!in_ready);
        end
    endtask

    // Stops offering and waits until every predicted angle has come out.
    task automatic wait_for_results;
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (results_pending != 0)
                @(negedge clk);
        end
    endtask

    function automatic coord_t extreme_coord();
        begin
            case ($urandom_range(0, 5))
                0:       return 16'sh8000;
                1:       return 16'sh7FFF;
                2:       return 16'sh0000;
                3:       return -16'sd1;
                4:       return 16'sd1;
                default: return coord_t'($urandom);
            endcase
        end
    endfunction

    // One random transaction. Besides fully random points it favors the
    // interesting geometry: equal x coordinates, short vectors whose angle is
    // coarse, wrap-around differences at the extremes, and horizontal vectors.
    task automatic send_random_pair;
        coord_t cx;
        coord_t cy;
        coord_t px;
        coord_t py;
        logic signed [7:0] off_x;
        logic signed [7:0] off_y;
        int kind;
        begin
            cx    = coord_t'($urandom);
            cy    = coord_t'($urandom);
            px    = coord_t'($urandom);
            py    = coord_t'($urandom);
            off_x = 8'($urandom);
            off_y = 8'($urandom);
            kind  = $urandom_range(0, 99);
            if (kind < 40)
            begin
                // Fully random points.
            end
            else if (kind < 55)
            begin
                // Equal x: dx is forced negative, sometimes with a zero vector.
                px = cx;
                if ($urandom_range(0, 3) == 0)
                    py = cy;
            end
            else if (kind < 80)
            begin
                // Short vector around a random center; may wrap at the edges.
                px = cx - {{(COORD_WIDTH_DEF-8){off_x[7]}}, off_x};
                py = cy - {{(COORD_WIDTH_DEF-8){off_y[7]}}, off_y};
            end
            else if (kind < 92)
            begin
                cx = extreme_coord();
                cy = extreme_coord();
                px = extreme_coord();
                py = extreme_coord();
            end
            else
            begin
                // Horizontal vector, zero y difference.
                py = cy;
            end
            send_point_pair(cx, cy, px, py);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        center_x = '0;
        center_y = '0;
        point_x  = '0;
        point_y  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed transactions, no idling.
        // Zero vector: reads as half a turn.
        send_point_pair(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        // Equal x with y above and below: vertical, leaning to negative x.
        send_point_pair(16'sd5, 16'sd100, 16'sd5, 16'sd0);
        send_point_pair(16'sd5, -16'sd100, 16'sd5, 16'sd0);
        send_point_pair(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        send_point_pair(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF);
        // Along the axes.
        send_point_pair(16'sd10, 16'sd0, 16'sd0, 16'sd0);
        send_point_pair(-16'sd10, 16'sd0, 16'sd0, 16'sd0);
        send_point_pair(16'sd1, 16'sd0, 16'sd0, 16'sd0);
        // Diagonals in all four quadrants.
        send_point_pair(16'sd7, 16'sd7, 16'sd0, 16'sd0);
        send_point_pair(-16'sd7, 16'sd7, 16'sd0, 16'sd0);
        send_point_pair(-16'sd7, -16'sd7, 16'sd0, 16'sd0);
        send_point_pair(16'sd7, -16'sd7, 16'sd0, 16'sd0);
        // Largest differences, which need one bit more than a coordinate.
        send_point_pair(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
        send_point_pair(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
        send_point_pair(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
        send_point_pair(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        send_point_pair(16'sh7FFF, 16'sd0, 16'sh8000, 16'sd0);
        send_point_pair(16'sh8000, 16'sd0, 16'sh7FFF, 16'sd0);
        // Just below a full turn: rounds over to zero.
        send_point_pair(16'sh7FFF, -16'sd1, 16'sh8000, 16'sd0);
        // Just above half a turn and just below it.
        send_point_pair(16'sh8000, -16'sd1, 16'sh7FFF, 16'sd0);
        send_point_pair(16'sh8000, 16'sd1, 16'sh7FFF, 16'sd0);
        // Unit steps.
        send_point_pair(16'sd1, 16'sd1, 16'sd0, 16'sd0);
        send_point_pair(-16'sd1, -16'sd1, 16'sd0, 16'sd0);
        wait_for_results();

        // Random traffic under four idle and stall mixes. Every phase ends
        // with the sender pausing until all results are back.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 49;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 49;
                end
                default:
                begin
                    idle_pct  = 8;
                    stall_pct = 8;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_random_pair();
            wait_for_results();
        end

        // Back-pressure: the receiver holds off for a long stretch while the
        // sender streams without gaps, so in_ready has to drop.
        idle_pct      = 0;
        stall_pct     = 0;
        long_hold_req = 1'b1;
        for (int n = 0; n < 3 * PIPE_DEPTH; n++)
            send_random_pair();
        wait_for_results();

        // Keep the clock running beyond the pipeline depth so that any stray result would still be caught.
        repeat (PIPE_DEPTH + 8) @(negedge clk);

        if (mismatch_count == 0 && results_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/vaft_pkg.sv
hw/rtl/vaft_prep.sv
hw/rtl/vaft_cell.sv
hw/rtl/vaft_round.sv
hw/rtl/vector_angle_full_turn.sv
hw/rtl/vaft_checker.sv
tb/angle_checker.sv
tb/tb.sv
